### sv/rxc_pkg.sv
// ----------------------------------------------------------------------------
// rxc_pkg
// Shared constants, beat types and helpers for the rotation XOR code checker.
// ----------------------------------------------------------------------------
package rxc_pkg;

    localparam int MAX_LEN = 31;
    localparam int LW      = $clog2(MAX_LEN + 1);
    localparam int DW      = 2 * MAX_LEN;
    localparam int NST     = MAX_LEN - 2;
    localparam int MIN_LEN = 3;
    localparam int RST_LEN = 7;

    typedef struct packed {
        logic [DW-1:0]      d;
        logic [MAX_LEN-1:0] r;
        logic [MAX_LEN-1:0] acc;
        logic               ok;
    } t_data;

    typedef struct packed {
        logic  valid;
        t_data data;
    } t_beat;

    function automatic logic [LW-1:0] eff_len(input logic [LW-1:0] v);
        logic [LW-1:0] l;
        l = v;
        if (v < LW'(MIN_LEN)) begin
            l = LW'(MIN_LEN);
        end else if ({1'b0, v} > (LW + 1)'(MAX_LEN)) begin
            l = LW'(MAX_LEN);
        end
        return l;
    endfunction

    function automatic logic [MAX_LEN-1:0] mask_of(input logic [LW-1:0] len);
        logic [MAX_LEN-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_LEN; b++) begin
            m[b] = ((LW + 1)'(b) < {1'b0, len});
        end
        return m;
    endfunction

endpackage

### sv/rxc_stage.sv
// ----------------------------------------------------------------------------
// rxc_stage
// One pipeline stage: next rotation, next partial XOR and its membership test
// against all rotations of the word.
// ----------------------------------------------------------------------------
module rxc_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rxc_pkg::LW-1:0]      i_idx,
    input  logic [rxc_pkg::LW-1:0]      i_len,
    input  logic [rxc_pkg::MAX_LEN-1:0] i_mask,
    input  rxc_pkg::t_beat              i_beat,
    output rxc_pkg::t_beat              o_beat
);
    import rxc_pkg::*;

    logic  r_valid;
    t_data r_data;
    t_data n_data;

    always_comb begin
        logic hit;
        logic active;
        hit    = 1'b0;
        n_data = i_beat.data;
        n_data.r = ((i_beat.data.r << 1) & i_mask)
                 | MAX_LEN'(i_beat.data.r[i_len - LW'(1)]);
        n_data.acc = i_beat.data.acc ^ n_data.r;
        for (int s = 0; s < MAX_LEN; s++) begin
            if (((LW + 1)'(s) < {1'b0, i_len})
                && ((i_beat.data.d[s +: MAX_LEN] & i_mask) == n_data.acc)) begin
                hit = 1'b1;
            end
        end
        active    = (({1'b0, i_idx} + (LW + 1)'(2)) <= {1'b0, i_len});
        n_data.ok = i_beat.data.ok & (~active | hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_beat = '{valid: r_valid, data: r_data};

endmodule

### sv/rotation_xor_code_checker.sv
// ----------------------------------------------------------------------------
// rotation_xor_code_checker
// Checks candidate code words for the cyclic rotation XOR property.
// ----------------------------------------------------------------------------
// One candidate is taken every cycle and busy stays low; each result appears
// for one cycle with o_strobe once its start beat has passed through an input
// register, one stage per partial XOR of rotations (29 stages, one partial
// XOR tested against all rotations in each), and an output register. Results
// leave in input order and cannot be held off. Write code_length only while
// no beat is in flight.
module rotation_xor_code_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rxc_pkg::MAX_LEN-1:0] i_candidate,
    input  logic                        i_cfg_we,
    input  logic [rxc_pkg::LW-1:0]      i_cfg_wdata,
    output logic                        o_strobe,
    output logic                        o_passes,
    output logic [rxc_pkg::MAX_LEN-1:0] o_mirrored,
    output logic [rxc_pkg::MAX_LEN-1:0] o_echoed
);
    import rxc_pkg::*;

    logic [LW-1:0]      r_len;
    logic [MAX_LEN-1:0] r_mask;
    logic               r_in_valid;
    t_data              r_in_data;
    t_data              n_in_data;
    t_beat              w_beat [0:NST];
    logic               r_out_strobe;
    logic               r_passes;
    logic [MAX_LEN-1:0] r_mirrored;
    logic [MAX_LEN-1:0] r_echoed;
    logic [MAX_LEN-1:0] n_mirrored;
    logic [MAX_LEN-1:0] n_echoed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LW'(RST_LEN);
            r_mask <= mask_of(LW'(RST_LEN));
        end else if (i_cfg_we) begin
            r_len  <= eff_len(i_cfg_wdata);
            r_mask <= mask_of(eff_len(i_cfg_wdata));
        end
    end

    assign busy = 1'b0;

    always_comb begin
        logic [MAX_LEN-1:0] w;
        w = i_candidate & r_mask;
        n_in_data.d   = DW'(w) | (DW'(w) << r_len);
        n_in_data.r   = w;
        n_in_data.acc = w;
        n_in_data.ok  = ~(^w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_data <= n_in_data;
    end

    assign w_beat[0] = '{valid: r_in_valid, data: r_in_data};

    for (genvar g = 0; g < NST; g++) begin : g_stage
        rxc_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (LW'(g + 1)),
            .i_len   (r_len),
            .i_mask  (r_mask),
            .i_beat  (w_beat[g]),
            .o_beat  (w_beat[g + 1])
        );
    end

    always_comb begin
        logic [MAX_LEN-1:0] rev;
        n_echoed = w_beat[NST].data.d[MAX_LEN-1:0] & r_mask;
        for (int b = 0; b < MAX_LEN; b++) begin
            rev[b] = n_echoed[MAX_LEN - 1 - b];
        end
        n_mirrored = rev >> (LW'(MAX_LEN) - r_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= w_beat[NST].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_passes   <= w_beat[NST].data.ok;
        r_mirrored <= n_mirrored;
        r_echoed   <= n_echoed;
    end

    assign o_strobe   = r_out_strobe;
    assign o_passes   = r_passes;
    assign o_mirrored = r_mirrored;
    assign o_echoed   = r_echoed;

    a_start_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> w_beat[0].valid)
        else $error("start beat not captured");

    a_pass_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_passes) |-> (^o_echoed) == 1'b0)
        else $error("pass reported for odd weight word");

    a_mirror_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $countones(o_mirrored) == $countones(o_echoed))
        else $error("mirrored word weight mismatch");

endmodule

### tb/rotation_xor_code_checker_tb.sv
// ----------------------------------------------------------------------------
// rotation_xor_code_checker_tb
// Self-checking bench for the rotation XOR code checker.
// ----------------------------------------------------------------------------
// Candidates are sent in bursts of random length, separated by random gaps.
// Each accepted beat is run through a behavioral model of the rotation XOR
// test. The model gives the pass flag, the mirrored word and the echoed word.
// Results are matched in order against these predictions. The code length is
// changed between phases, once all results are back. It is run through the
// short clamp values, both extremes and a spread in between. For short
// lengths the bench collects the passing words by brute force. About half of
// the beats at those lengths are valid code words with random bits above the
// code length.
// ----------------------------------------------------------------------------
module rotation_xor_code_checker_tb;
    import rxc_pkg::*;

    localparam int WD_LIMIT    = 2000;
    localparam int PHASE_BEATS = 105;
    localparam int SEARCH_MAX  = 12;

    typedef struct packed {
        logic               passes;
        logic [MAX_LEN-1:0] mirrored;
        logic [MAX_LEN-1:0] echoed;
    } t_verdict;

    class t_verdict_board;
        logic [LW-1:0] code_len;
        t_verdict      pending_verdicts[$];
        int            errors;
        int            beats;
        int            verdicts;
        int            passed;

        function new();
            code_len = LW'(RST_LEN);
            errors   = 0;
            beats    = 0;
            verdicts = 0;
            passed   = 0;
        endfunction

        function int word_len();
            return (int'(code_len) < MIN_LEN) ? MIN_LEN : int'(code_len);
        endfunction

        function t_verdict rotation_verdict(logic [MAX_LEN-1:0] cand);
            logic [MAX_LEN-1:0] rot [0:MAX_LEN-1];
            logic [MAX_LEN-1:0] m;
            logic [MAX_LEN-1:0] w;
            logic [MAX_LEN-1:0] acc;
            logic [MAX_LEN-1:0] mir;
            logic               ok;
            logic               hit;
            int                 n;
            t_verdict           v;
            n = word_len();
            m = {MAX_LEN{1'b1}} >> (MAX_LEN - n);
            w = cand & m;
            rot[0] = w;
            for (int i = 1; i < n; i++) begin
                rot[i] = ((rot[i-1] << 1) & m) | ((rot[i-1] >> (n - 1)) & MAX_LEN'(1));
            end
            acc = w;
            ok  = 1'b1;
            for (int i = 1; i < n; i++) begin
                acc = acc ^ rot[i];
                hit = 1'b0;
                for (int j = 0; j < n; j++) begin
                    if (acc == rot[j]) begin
                        hit = 1'b1;
                    end
                end
                if (!hit && i != n - 1) begin
                    ok = 1'b0;
                end
            end
            if (acc != '0) begin
                ok = 1'b0;
            end
            mir = '0;
            for (int i = 0; i < n; i++) begin
                mir[n-1-i] = w[i];
            end
            v.passes   = ok;
            v.mirrored = mir;
            v.echoed   = w;
            return v;
        endfunction

        function void note_candidate(logic [MAX_LEN-1:0] cand);
            pending_verdicts.insert(pending_verdicts.size(), rotation_verdict(cand));
            beats++;
        endfunction

        function void check_verdict(logic p, logic [MAX_LEN-1:0] mir,
                                    logic [MAX_LEN-1:0] echo);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no candidate pending");
                errors++;
                return;
            end
            v = pending_verdicts.pop_front();
            verdicts++;
            if (v.passes) begin
                passed++;
            end
            if (p !== v.passes) begin
                $error("passes: expected %0d, got %0d", v.passes, p);
                errors++;
            end
            if (mir !== v.mirrored) begin
                $error("mirrored: expected %h, got %h", v.mirrored, mir);
                errors++;
            end
            if (echo !== v.echoed) begin
                $error("echoed: expected %h, got %h", v.echoed, echo);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [MAX_LEN-1:0] i_candidate;
    logic               i_cfg_we;
    logic [LW-1:0]      i_cfg_wdata;
    logic               o_strobe;
    logic               o_passes;
    logic [MAX_LEN-1:0] o_mirrored;
    logic [MAX_LEN-1:0] o_echoed;

    t_verdict_board     board = new();
    logic [MAX_LEN-1:0] good_words[$];
    int                 burst_left  = 0;
    int                 idle_cycles = 0;
    int                 phases      = 1;

    rotation_xor_code_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_candidate (i_candidate),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_passes    (o_passes),
        .o_mirrored  (o_mirrored),
        .o_echoed    (o_echoed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_candidate(i_candidate);
            end
            if (o_strobe) begin
                board.check_verdict(o_passes, o_mirrored, o_echoed);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WD_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_beat(input logic [MAX_LEN-1:0] cand);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start       <= 1'b1;
        i_candidate <= cand;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        burst_left = 0;
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [LW-1:0] len);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        board.code_len = len;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // all passing words of the current length, where the length allows a search; else only the zero word
    task automatic collect_good_words();
        t_verdict v;
        int       n;
        good_words.delete();
        n = board.word_len();
        if (n <= SEARCH_MAX) begin
            for (int w = 0; w < (1 << n); w++) begin
                v = board.rotation_verdict(MAX_LEN'(w));
                if (v.passes) begin
                    good_words.insert(good_words.size(), MAX_LEN'(w));
                end
            end
        end else begin
            good_words.insert(good_words.size(), '0);
        end
    endtask

    task automatic run_phase(input logic [LW-1:0] len, input int count);
        logic [MAX_LEN-1:0] m;
        logic [MAX_LEN-1:0] c;
        int                 pick;
        drain();
        write_len(len);
        phases++;
        collect_good_words();
        m = {MAX_LEN{1'b1}} >> (MAX_LEN - board.word_len());
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 9);
            c    = MAX_LEN'($urandom);
            if (pick < 5) begin
                c = good_words[$urandom_range(0, good_words.size() - 1)] | (c & ~m);
            end else if (pick == 5) begin
                c = c & ~m;
            end
            push_beat(c);
        end
    endtask

    initial begin
        logic [LW-1:0] lens[$];
        start       = 1'b0;
        i_candidate = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset length of 7
        push_beat(31'h0000_0000);
        push_beat(31'h7FFF_FFFF);
        push_beat(31'h0000_007F);
        push_beat(31'h0000_0001);
        push_beat(31'h0000_0040);
        push_beat(31'h7FFF_FF80);
        push_beat(31'h0000_0003);
        push_beat(31'h0000_002A);
        push_beat(31'h0000_0055);
        push_beat(31'h0000_001B);

        // longest code
        drain();
        write_len(LW'(MAX_LEN));
        phases++;
        push_beat(31'h0000_0000);
        push_beat(31'h7FFF_FFFF);
        push_beat(31'h5555_5555);
        push_beat(31'h4000_0000);
        push_beat(31'h0000_0001);
        push_beat(31'h0000_0003);

        lens = '{5'd3, 5'd31, 5'd0, 5'd1, 5'd2, 5'd4, 5'd5, 5'd6, 5'd8,
                 5'd10, 5'd11, 5'd12, 5'd16, 5'd23, 5'd30};
        lens.insert(lens.size(), LW'($urandom_range(3, 31)));
        lens.insert(lens.size(), LW'($urandom_range(0, 31)));
        foreach (lens[p]) begin
            run_phase(lens[p], PHASE_BEATS);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (board.pending_verdicts.size() != 0) begin
            $error("%0d results never arrived", board.pending_verdicts.size());
            board.errors++;
        end
        $display("Sent %0d candidates over %0d code length settings", board.beats, phases);
        $display("Checked %0d results, %0d of them passing words", board.verdicts,
                 board.passed);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
